// ===== rtl/fad_pkg.sv =====
`default_nettype none

package fad_pkg;

  // command codes carried in the low bits of the input word
  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_DUMP       = 3'd4
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_DUMP
  } state_t;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned ITEM_W  = 32;
  localparam int unsigned IN_TDATA_W = 40;

  // controller to datapath
  typedef struct packed {
    logic exec;       // input word accepted, act on op
    cmd_t op;
    logic pop_load;   // move read data of a pop to the output
    logic dump_load;  // move read data of a dump to the output, step pointer
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic out_free;
    logic dump_last;
  } dst_t;

endpackage

`default_nettype wire

// ===== rtl/fad_ctrl.sv =====
`default_nettype none

module fad_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_tvalid,
  output logic             in_tready,
  input  fad_pkg::cmd_t    cmd,
  input  fad_pkg::dst_t    dst,
  output fad_pkg::ctl_t    ctl
);
  import fad_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    ctl.exec      = 1'b0;
    ctl.op        = cmd;
    ctl.pop_load  = 1'b0;
    ctl.dump_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = dst.out_free;
        if (in_tvalid && dst.out_free) begin
          ctl.exec = 1'b1;
          case (cmd)
            CMD_POP_FRONT, CMD_POP_BACK: begin
              if (!dst.empty) state_nxt = S_POP;
            end
            CMD_DUMP: begin
              if (!dst.empty) state_nxt = S_DUMP;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_POP: begin
        if (dst.out_free) begin
          ctl.pop_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_DUMP: begin
        if (dst.out_free) begin
          ctl.dump_load = 1'b1;
          if (dst.dump_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/fad_dpath.sv =====
`default_nettype none

module fad_dpath #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire [fad_pkg::VALUE_W-1:0]     in_value,
  input  fad_pkg::ctl_t                  ctl,
  output fad_pkg::dst_t                  dst,
  input  wire                            out_tready,
  output logic                           out_valid,
  output fad_pkg::status_t               out_status,
  output logic [fad_pkg::ITEM_W-1:0]     out_item,
  output logic                           out_last
);
  import fad_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] TOP = AW'(DEPTH - 1);

  logic [DATA_WIDTH-1:0] mem_r [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;
  logic [AW-1:0]         head_r, head_nxt;
  logic [AW-1:0]         tail_r, tail_nxt;
  logic [AW-1:0]         ptr_r, ptr_nxt;
  logic                  empty_r, empty_nxt;

  logic                  out_valid_r, out_valid_nxt;
  status_t               status_r, status_nxt;
  logic [ITEM_W-1:0]     item_r, item_nxt;
  logic                  last_r, last_nxt;

  logic                  wr_en, rd_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [95:0]           wext, rext;
  logic [DATA_WIDTH-1:0] wdata;
  logic [ITEM_W-1:0]     push_item, rd_item;
  logic                  is_push, is_pop;

  // value is zero-extended or cut to the stored width, items zero-extended back
  assign wext      = {64'd0, in_value};
  assign wdata     = wext[DATA_WIDTH-1:0];
  assign push_item = ITEM_W'({{(96-DATA_WIDTH){1'b0}}, wdata});
  assign rext      = {{(96-DATA_WIDTH){1'b0}}, rdata_r};
  assign rd_item   = rext[ITEM_W-1:0];

  assign is_push = (ctl.op == CMD_PUSH_FRONT) || (ctl.op == CMD_PUSH_BACK);
  assign is_pop  = (ctl.op == CMD_POP_FRONT) || (ctl.op == CMD_POP_BACK);

  assign dst.empty     = empty_r;
  assign dst.out_free  = !out_valid_r || out_tready;
  assign dst.dump_last = (ptr_r == tail_r);

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    ptr_nxt       = ptr_r;
    empty_nxt     = empty_r;
    wr_en         = 1'b0;
    wr_addr       = head_r;
    rd_en         = 1'b0;
    rd_addr       = head_r;
    out_valid_nxt = out_valid_r && !out_tready;
    status_nxt    = status_r;
    item_nxt      = item_r;
    last_nxt      = last_r;

    if (ctl.exec) begin
      if (is_push) begin
        out_valid_nxt = 1'b1;
        last_nxt      = 1'b1;
        status_nxt    = ST_OK;
        item_nxt      = push_item;
        if (empty_r) begin
          // first entry always lands in slot 0
          head_nxt  = '0;
          tail_nxt  = '0;
          empty_nxt = 1'b0;
          wr_en     = 1'b1;
          wr_addr   = '0;
        end else if (ctl.op == CMD_PUSH_FRONT && head_r != '0) begin
          head_nxt = head_r - 1'b1;
          wr_en    = 1'b1;
          wr_addr  = head_r - 1'b1;
        end else if (ctl.op == CMD_PUSH_BACK && tail_r != TOP) begin
          tail_nxt = tail_r + 1'b1;
          wr_en    = 1'b1;
          wr_addr  = tail_r + 1'b1;
        end else begin
          status_nxt = ST_OVERFLOW;
          item_nxt   = '0;
        end
      end else if (is_pop || ctl.op == CMD_DUMP) begin
        if (empty_r) begin
          out_valid_nxt = 1'b1;
          last_nxt      = 1'b1;
          status_nxt    = ST_EMPTY;
          item_nxt      = '0;
        end else if (is_pop) begin
          rd_en   = 1'b1;
          rd_addr = (ctl.op == CMD_POP_FRONT) ? head_r : tail_r;
          if (head_r == tail_r) begin
            head_nxt  = '0;
            tail_nxt  = '0;
            empty_nxt = 1'b1;
          end else if (ctl.op == CMD_POP_FRONT) begin
            head_nxt = head_r + 1'b1;
          end else begin
            tail_nxt = tail_r - 1'b1;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = head_r;
          ptr_nxt = head_r;
        end
      end
    end

    if (ctl.pop_load) begin
      out_valid_nxt = 1'b1;
      last_nxt      = 1'b1;
      status_nxt    = ST_OK;
      item_nxt      = rd_item;
    end

    if (ctl.dump_load) begin
      out_valid_nxt = 1'b1;
      last_nxt      = dst.dump_last;
      status_nxt    = ST_OK;
      item_nxt      = rd_item;
      if (!dst.dump_last) begin
        ptr_nxt = ptr_r + 1'b1;
        rd_en   = 1'b1;
        rd_addr = ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      empty_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      empty_r     <= empty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    status_r <= status_nxt;
    item_r   <= item_nxt;
    last_r   <= last_nxt;
  end

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wdata;
    if (rd_en) rdata_r <= mem_r[rd_addr];
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_item   = item_r;
  assign out_last   = last_r;

endmodule

`default_nettype wire

// ===== rtl/fixed_array_deque_core.sv =====
`default_nettype none

// channel  dir  handshake            payload
// in_      in   in_tvalid/tready     in_tdata: command, value
// out_     out  out_tvalid/tready    out_tdata: item, out_tuser: status, out_tlast: last
//
// push front/back: one word per cycle while the output is free; output is registered
// pop: read through the registered read port of the entry store, then loaded to the output
// dump: one memory read per entry through the same port
// reset clears head, tail, empty flag and output valid; the store itself is not cleared
// a stalled output holds the controller and stops new input words

module fixed_array_deque_core #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [39:0] in_tdata,    // [2:0] command, [34:3] value, [39:35] zero
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,   // [31:0] item
  output logic [1:0]  out_tuser,   // [1:0] status
  output logic        out_tlast
);
  import fad_pkg::*;

  ctl_t    ctl;
  dst_t    dst;
  cmd_t    cmd;
  status_t status;

  // command field as the controller sees it
  assign cmd = cmd_t'(in_tdata[CMD_W-1:0]);

  fad_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .dst       (dst),
    .ctl       (ctl)
  );

  fad_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_value   (in_tdata[CMD_W +: VALUE_W]),
    .ctl        (ctl),
    .dst        (dst),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_status (status),
    .out_item   (out_tdata),
    .out_last   (out_tlast)
  );

  assign out_tuser = status;

  // at most one action on the datapath per cycle
  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.exec, ctl.pop_load, ctl.dump_load}))
    else $error("more than one datapath action in a cycle");

  // memory results only move into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.pop_load || ctl.dump_load) |-> dst.out_free)
    else $error("read data loaded into a busy output register");

  // no input word is taken while a read result is being delivered
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.pop_load || ctl.dump_load) |-> !in_tready)
    else $error("input ready during pop or dump delivery");

  // a pop on a filled queue blocks input for the read cycle
  a_pop_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.exec && !dst.empty &&
     (ctl.op == CMD_POP_FRONT || ctl.op == CMD_POP_BACK)) |=> !in_tready)
    else $error("input taken during pop read");

endmodule

`default_nettype wire

// ===== tb/fixed_array_deque_core_tb.sv =====
`timescale 1ns / 100ps

module fixed_array_deque_core_tb;
  import fad_pkg::*;

  localparam int unsigned TB_DEPTH     = 16;
  localparam int unsigned RANDOM_CMDS  = 320;
  localparam int unsigned LONG_HOLD    = 200;  // receiver hold-off, in cycles
  localparam int unsigned DRAIN_CYCLES = 20;   // quiet time after the last result
  localparam int unsigned NUM_ROWS     = 23;

  // command codes the block ignores
  localparam logic [2:0] CMD_UNUSED_LO  = 3'd5;
  localparam logic [2:0] CMD_UNUSED_MID = 3'd6;
  localparam logic [2:0] CMD_UNUSED_HI  = 3'd7;

  // one output word as the block should send it
  typedef struct packed {
    status_t     status;
    logic [31:0] item;
    logic        last;
  } out_word_t;

  // one row of the directed table; typed rows carry their single expected word
  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] value;
    bit          typed;
    status_t     status;
    logic [31:0] item;
  } dir_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;   // [2:0] command, [34:3] value, [39:35] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [31:0] item
  logic [1:0]  out_tuser;         // [1:0] status
  logic        out_tlast;

  fixed_array_deque_core #(
    .DEPTH      (TB_DEPTH),
    .DATA_WIDTH (32)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #1 clk = ~clk;

  // mirror of the deque contents and pointers
  logic [31:0] mirror_mem [TB_DEPTH];
  int unsigned mirror_head;
  int unsigned mirror_tail;
  bit          mirror_empty;

  out_word_t   step_words [$];       // words caused by the command being applied
  out_word_t   pending_words [$];    // words still owed by the block, oldest first
  out_word_t   typed_words [int];    // hand-written expectations, by accept index
  dir_row_t    directed_rows [NUM_ROWS];

  int unsigned accept_count;
  int unsigned cmd_count;
  int unsigned words_checked;
  int unsigned overflow_seen;
  int unsigned empty_seen;
  int unsigned dumps_sent;
  int unsigned error_count;

  bit steady;          // no random gaps from the sender and no new random receiver stalls while set
  bit hold_request;    // asks the receiver for one long hold-off

  task automatic add_word(input status_t st, input logic [31:0] item, input logic last);
    step_words.push_back('{st, item, last});
  endtask

  // work out the words one command causes and advance the mirror
  task automatic deque_apply(input logic [2:0] cmd, input logic [31:0] val);
    logic [31:0] got;
    step_words.delete();
    case (cmd)
      CMD_PUSH_FRONT: begin
        if (mirror_empty) begin
          // empty queue: item lands in slot 0 from either end
          mirror_head  = 0;
          mirror_tail  = 0;
          mirror_empty = 1'b0;
          mirror_mem[0] = val;
          add_word(ST_OK, val, 1'b1);
        end else if (mirror_head != 0) begin
          mirror_head--;
          mirror_mem[mirror_head] = val;
          add_word(ST_OK, val, 1'b1);
        end else begin
          add_word(ST_OVERFLOW, '0, 1'b1);
        end
      end
      CMD_PUSH_BACK: begin
        if (mirror_empty) begin
          mirror_head  = 0;
          mirror_tail  = 0;
          mirror_empty = 1'b0;
          mirror_mem[0] = val;
          add_word(ST_OK, val, 1'b1);
        end else if (mirror_tail < TB_DEPTH - 1) begin
          mirror_tail++;
          mirror_mem[mirror_tail] = val;
          add_word(ST_OK, val, 1'b1);
        end else begin
          add_word(ST_OVERFLOW, '0, 1'b1);
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (mirror_empty) begin
          add_word(ST_EMPTY, '0, 1'b1);
        end else begin
          got = (cmd == CMD_POP_FRONT) ? mirror_mem[mirror_head] : mirror_mem[mirror_tail];
          if (mirror_head == mirror_tail) begin
            // last entry gone, back to the reset state
            mirror_head  = 0;
            mirror_tail  = 0;
            mirror_empty = 1'b1;
          end else if (cmd == CMD_POP_FRONT) begin
            mirror_head++;
          end else begin
            mirror_tail--;
          end
          add_word(ST_OK, got, 1'b1);
        end
      end
      CMD_DUMP: begin
        if (mirror_empty) begin
          add_word(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int unsigned i = mirror_head; i <= mirror_tail; i++)
            add_word(ST_OK, mirror_mem[i], i == mirror_tail);
        end
      end
      default: ;  // unused codes: no state change, no words
    endcase
  endtask

  // gap lengths: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // push values: mostly random, sometimes the extremes
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h7fff_ffff;
      3:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // offer one word and wait for it to be taken
  task automatic send_word(input logic [2:0] cmd, input logic [31:0] val);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, val, cmd};
    // ready is sampled at the edge itself, before the block updates
    @(posedge clk iff in_tready);
    if (cmd <= CMD_DUMP) cmd_count++;
    if (cmd == CMD_DUMP) dumps_sent++;
  endtask

  // pick a command for the mixed phases
  function automatic logic [2:0] pick_cmd();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 28) return CMD_PUSH_FRONT;
    if (r < 56) return CMD_PUSH_BACK;
    if (r < 72) return CMD_POP_FRONT;
    if (r < 88) return CMD_POP_BACK;
    if (r < 96) return CMD_DUMP;
    return 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        for (int unsigned k = 0; k < LONG_HOLD; k++) @(posedge clk);
      end else if (stall_left != 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (!steady && $urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  // watch both channels: predict on accepted commands, check accepted words
  always @(posedge clk) begin : scoreboard
    out_word_t exp_w;
    out_word_t got_w;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        deque_apply(in_tdata[2:0], in_tdata[34:3]);
        if (typed_words.exists(accept_count))
          pending_words.push_back(typed_words[accept_count]);
        else
          foreach (step_words[k]) pending_words.push_back(step_words[k]);
        accept_count++;
      end
      if (out_tvalid && out_tready) begin
        got_w = '{status_t'(out_tuser), out_tdata, out_tlast};
        if (got_w.status == ST_OVERFLOW) overflow_seen++;
        if (got_w.status == ST_EMPTY) empty_seen++;
        if (pending_words.size() == 0) begin
          $display("%0t: unexpected word status=%0d item=%h last=%b",
                   $time, got_w.status, got_w.item, got_w.last);
          error_count++;
        end else begin
          exp_w = pending_words.pop_front();
          words_checked++;
          if (got_w.status !== exp_w.status) begin
            $display("%0t: status mismatch expected=%0d actual=%0d",
                     $time, exp_w.status, got_w.status);
            error_count++;
          end
          if (got_w.item !== exp_w.item) begin
            $display("%0t: item mismatch expected=%h actual=%h",
                     $time, exp_w.item, got_w.item);
            error_count++;
          end
          if (got_w.last !== exp_w.last) begin
            $display("%0t: last mismatch expected=%b actual=%b",
                     $time, exp_w.last, got_w.last);
            error_count++;
          end
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned start_count;
    int unsigned n;
    int unsigned phase;
    logic [2:0]  cmd;

    mirror_head  = 0;
    mirror_tail  = 0;
    mirror_empty = 1'b1;
    foreach (mirror_mem[i]) mirror_mem[i] = '0;

    // directed table: typed rows hold what can be read off directly
    directed_rows = '{
      '{CMD_POP_FRONT,  32'h0000_0000, 1'b1, ST_EMPTY,    32'h0000_0000},  // pop on reset
      '{CMD_POP_BACK,   32'hffff_ffff, 1'b1, ST_EMPTY,    32'h0000_0000},
      '{CMD_DUMP,       32'h0000_0000, 1'b1, ST_EMPTY,    32'h0000_0000},  // empty dump
      '{CMD_UNUSED_LO,  32'h1234_5678, 1'b0, ST_OK,       32'h0000_0000},  // ignored
      '{CMD_UNUSED_HI,  32'hffff_ffff, 1'b0, ST_OK,       32'h0000_0000},  // ignored
      '{CMD_PUSH_FRONT, 32'h7fff_ffff, 1'b1, ST_OK,       32'h7fff_ffff},  // empty, slot 0
      '{CMD_PUSH_BACK,  32'h8000_0000, 1'b1, ST_OK,       32'h8000_0000},
      '{CMD_PUSH_BACK,  32'hffff_ffff, 1'b1, ST_OK,       32'hffff_ffff},
      '{CMD_PUSH_FRONT, 32'h0000_1234, 1'b1, ST_OVERFLOW, 32'h0000_0000},  // head at 0
      '{CMD_DUMP,       32'h0000_0000, 1'b0, ST_OK,       32'h0000_0000},
      '{CMD_POP_FRONT,  32'h0000_0000, 1'b0, ST_OK,       32'h0000_0000},
      '{CMD_PUSH_FRONT, 32'h0000_0000, 1'b0, ST_OK,       32'h0000_0000},  // head 1 to 0
      '{CMD_POP_BACK,   32'h0000_0000, 1'b0, ST_OK,       32'h0000_0000},
      '{CMD_POP_BACK,   32'h0000_0000, 1'b0, ST_OK,       32'h0000_0000},
      '{CMD_POP_FRONT,  32'h0000_0000, 1'b0, ST_OK,       32'h0000_0000},  // only entry
      '{CMD_DUMP,       32'h0000_0000, 1'b1, ST_EMPTY,    32'h0000_0000},
      '{CMD_PUSH_BACK,  32'h0000_0000, 1'b1, ST_OK,       32'h0000_0000},  // empty, slot 0
      '{CMD_POP_BACK,   32'h0000_0000, 1'b1, ST_OK,       32'h0000_0000},
      '{CMD_PUSH_BACK,  32'ha5a5_a5a5, 1'b1, ST_OK,       32'ha5a5_a5a5},
      '{CMD_PUSH_FRONT, 32'h5a5a_5a5a, 1'b1, ST_OVERFLOW, 32'h0000_0000},
      '{CMD_DUMP,       32'h0000_0000, 1'b0, ST_OK,       32'h0000_0000},  // one entry
      '{CMD_UNUSED_MID, 32'h0f0f_0f0f, 1'b0, ST_OK,       32'h0000_0000},  // ignored
      '{CMD_POP_FRONT,  32'h0000_0000, 1'b0, ST_OK,       32'h0000_0000}
    };

    // hold the synchronous reset, then release it
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].typed)
        typed_words[i] = '{directed_rows[i].status, directed_rows[i].item, 1'b1};
      send_word(directed_rows[i].cmd, directed_rows[i].value);
    end

    start_count = cmd_count;

    // back pressure: receiver holds off while pushes and dumps keep coming
    steady       = 1'b1;
    hold_request = 1'b1;
    for (int unsigned k = 0; k < 24; k++)
      send_word(($urandom_range(0, 4) == 0) ? CMD_DUMP : CMD_PUSH_BACK, pick_value());
    steady = 1'b0;

    while (cmd_count - start_count < RANDOM_CMDS) begin
      steady = ($urandom_range(0, 5) == 0);
      phase  = $urandom_range(0, 9);
      if (phase <= 2) begin
        // fill from the back, usually far enough to hit the top slot
        n = $urandom_range(4, 20);
        repeat (n)
          send_word(($urandom_range(0, 9) == 0) ? CMD_DUMP : CMD_PUSH_BACK, pick_value());
      end else if (phase == 3) begin
        // open room at the front, then push past slot 0
        n = $urandom_range(1, 8);
        repeat (n) send_word(CMD_POP_FRONT, pick_value());
        repeat (n + $urandom_range(1, 3)) send_word(CMD_PUSH_FRONT, pick_value());
      end else if (phase <= 5) begin
        // drain from both ends, often running past empty
        n = $urandom_range(3, 18);
        repeat (n)
          send_word($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK, pick_value());
      end else if (phase <= 8) begin
        n = $urandom_range(5, 20);
        repeat (n) send_word(pick_cmd(), pick_value());
      end else begin
        // noise: unused codes among random commands
        n = $urandom_range(1, 4);
        repeat (n) begin
          cmd = $urandom_range(0, 1) ? 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI))
                                     : pick_cmd();
          send_word(cmd, $urandom);
        end
      end
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    // wait for every owed word, then a quiet stretch for strays
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d commands taken (%0d dumps), %0d words checked",
             cmd_count, dumps_sent, words_checked);
    $display("run: %0d overflow and %0d empty replies seen", overflow_seen, empty_seen);
    if (error_count == 0 && pending_words.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
